### sv/esc_pkg.sv
// Package for the epoch-seconds to calendar unit: field widths, calendar
// constants, reciprocals, the control-word layout and the read-only sequencer program.
// Depends on nothing.
`default_nettype none

package esc_pkg;

   // Field widths of the input and result items
   localparam int unsigned EPOCH_W   = 31;
   localparam int unsigned YEAR_W    = 11;
   localparam int unsigned MONTH_W   = 4;
   localparam int unsigned MDAY_W    = 5;
   localparam int unsigned YDAY_W    = 9;
   localparam int unsigned WDAY_W    = 3;
   localparam int unsigned HOUR_W    = 5;
   localparam int unsigned MIN_W     = 6;
   localparam int unsigned SEC_W     = 6;

   // Internal widths
   localparam int unsigned DAYS_W    = 15;  // whole days since the epoch, up to 24855
   localparam int unsigned TOD_W     = 17;  // seconds within a day, below 86400
   localparam int unsigned QDAY_W    = 11;  // day within a four-year block, below 1461
   localparam int unsigned PC_W      = 5;

   // Calendar constants
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned SECS_PER_HOUR = 60 * SECS_PER_MIN;
   localparam int unsigned SECS_PER_DAY  = 24 * SECS_PER_HOUR;
   localparam int unsigned DAYS_PER_QUAD = 4 * 365 + 1;
   localparam int unsigned BASE_YEAR     = 1970;
   localparam int unsigned BASE_WEEKDAY  = 4;
   localparam int unsigned DAYS_YEAR     = 365;

   // Reciprocals scaled by 2^31, rounded down; the estimate they give is
   // the true quotient or one short of it for any dividend below 2^31
   localparam int unsigned RECIP_SHIFT = EPOCH_W;
   localparam int unsigned RECIP_W     = 26;
   localparam int unsigned PROD_W      = EPOCH_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_DAY  = RECIP_W'((64'd1 << RECIP_SHIFT) / SECS_PER_DAY);
   localparam logic [RECIP_W-1:0] RECIP_QUAD = RECIP_W'((64'd1 << RECIP_SHIFT) / DAYS_PER_QUAD);
   localparam logic [RECIP_W-1:0] RECIP_HOUR = RECIP_W'((64'd1 << RECIP_SHIFT) / SECS_PER_HOUR);
   localparam logic [RECIP_W-1:0] RECIP_MIN  = RECIP_W'((64'd1 << RECIP_SHIFT) / SECS_PER_MIN);

   // Program addresses
   localparam logic [PC_W-1:0] PC_WAIT      = 5'd0;
   localparam logic [PC_W-1:0] PC_DAY_MUL   = 5'd1;
   localparam logic [PC_W-1:0] PC_DAY_QUO   = 5'd2;
   localparam logic [PC_W-1:0] PC_DAY_REM   = 5'd3;
   localparam logic [PC_W-1:0] PC_DAY_FIX   = 5'd4;
   localparam logic [PC_W-1:0] PC_SAVE_DAYS = 5'd5;
   localparam logic [PC_W-1:0] PC_QUAD_MUL  = 5'd6;
   localparam logic [PC_W-1:0] PC_QUAD_QUO  = 5'd7;
   localparam logic [PC_W-1:0] PC_QUAD_REM  = 5'd8;
   localparam logic [PC_W-1:0] PC_QUAD_FIX  = 5'd9;
   localparam logic [PC_W-1:0] PC_SAVE_QUAD = 5'd10;
   localparam logic [PC_W-1:0] PC_MONTH     = 5'd11;
   localparam logic [PC_W-1:0] PC_HOUR_MUL  = 5'd12;
   localparam logic [PC_W-1:0] PC_HOUR_QUO  = 5'd13;
   localparam logic [PC_W-1:0] PC_HOUR_REM  = 5'd14;
   localparam logic [PC_W-1:0] PC_HOUR_FIX  = 5'd15;
   localparam logic [PC_W-1:0] PC_SAVE_HOUR = 5'd16;
   localparam logic [PC_W-1:0] PC_MIN_MUL   = 5'd17;
   localparam logic [PC_W-1:0] PC_MIN_QUO   = 5'd18;
   localparam logic [PC_W-1:0] PC_MIN_REM   = 5'd19;
   localparam logic [PC_W-1:0] PC_MIN_FIX   = 5'd20;
   localparam logic [PC_W-1:0] PC_SAVE_MIN  = 5'd21;
   localparam logic [PC_W-1:0] PC_OUT       = 5'd22;

   typedef enum logic [3:0] {
      OP_WAIT,
      OP_MUL,
      OP_QUO,
      OP_REM,
      OP_FIX,
      OP_SAVE_DAYS,
      OP_SAVE_QUAD,
      OP_MONTH,
      OP_SAVE_HOUR,
      OP_SAVE_MIN,
      OP_OUT
   } op_type;

   typedef enum logic [1:0] {
      DSEL_DAY,
      DSEL_QUAD,
      DSEL_HOUR,
      DSEL_MIN
   } dsel_type;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_ACCEPT,
      COND_OUT_FREE
   } cond_type;

   // One control word: operation, divisor, jump condition and target
   typedef struct packed {
      op_type                op;
      dsel_type              dsel;
      cond_type              cond;
      logic [PC_W-1:0]       target;
   } uword_type;

   // Read-only program
   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '{op: OP_WAIT, dsel: DSEL_DAY, cond: COND_ALWAYS, target: PC_WAIT};
      case (pc)
         PC_WAIT:      w = '{OP_WAIT, DSEL_DAY, COND_ACCEPT, PC_DAY_MUL};
         PC_DAY_MUL:   w = '{OP_MUL, DSEL_DAY, COND_ALWAYS, PC_DAY_QUO};
         PC_DAY_QUO:   w = '{OP_QUO, DSEL_DAY, COND_ALWAYS, PC_DAY_REM};
         PC_DAY_REM:   w = '{OP_REM, DSEL_DAY, COND_ALWAYS, PC_DAY_FIX};
         PC_DAY_FIX:   w = '{OP_FIX, DSEL_DAY, COND_ALWAYS, PC_SAVE_DAYS};
         PC_SAVE_DAYS: w = '{OP_SAVE_DAYS, DSEL_DAY, COND_ALWAYS, PC_QUAD_MUL};
         PC_QUAD_MUL:  w = '{OP_MUL, DSEL_QUAD, COND_ALWAYS, PC_QUAD_QUO};
         PC_QUAD_QUO:  w = '{OP_QUO, DSEL_QUAD, COND_ALWAYS, PC_QUAD_REM};
         PC_QUAD_REM:  w = '{OP_REM, DSEL_QUAD, COND_ALWAYS, PC_QUAD_FIX};
         PC_QUAD_FIX:  w = '{OP_FIX, DSEL_QUAD, COND_ALWAYS, PC_SAVE_QUAD};
         PC_SAVE_QUAD: w = '{OP_SAVE_QUAD, DSEL_QUAD, COND_ALWAYS, PC_MONTH};
         PC_MONTH:     w = '{OP_MONTH, DSEL_HOUR, COND_ALWAYS, PC_HOUR_MUL};
         PC_HOUR_MUL:  w = '{OP_MUL, DSEL_HOUR, COND_ALWAYS, PC_HOUR_QUO};
         PC_HOUR_QUO:  w = '{OP_QUO, DSEL_HOUR, COND_ALWAYS, PC_HOUR_REM};
         PC_HOUR_REM:  w = '{OP_REM, DSEL_HOUR, COND_ALWAYS, PC_HOUR_FIX};
         PC_HOUR_FIX:  w = '{OP_FIX, DSEL_HOUR, COND_ALWAYS, PC_SAVE_HOUR};
         PC_SAVE_HOUR: w = '{OP_SAVE_HOUR, DSEL_HOUR, COND_ALWAYS, PC_MIN_MUL};
         PC_MIN_MUL:   w = '{OP_MUL, DSEL_MIN, COND_ALWAYS, PC_MIN_QUO};
         PC_MIN_QUO:   w = '{OP_QUO, DSEL_MIN, COND_ALWAYS, PC_MIN_REM};
         PC_MIN_REM:   w = '{OP_REM, DSEL_MIN, COND_ALWAYS, PC_MIN_FIX};
         PC_MIN_FIX:   w = '{OP_FIX, DSEL_MIN, COND_ALWAYS, PC_SAVE_MIN};
         PC_SAVE_MIN:  w = '{OP_SAVE_MIN, DSEL_MIN, COND_ALWAYS, PC_OUT};
         PC_OUT:       w = '{OP_OUT, DSEL_MIN, COND_OUT_FREE, PC_WAIT};
         default:      w = '{OP_WAIT, DSEL_DAY, COND_ALWAYS, PC_WAIT};
      endcase
      return w;
   endfunction

   // Divisor selected by a control word
   function automatic logic [EPOCH_W-1:0] divisor(input dsel_type sel);
      logic [EPOCH_W-1:0] d;
      case (sel)
         DSEL_DAY:  d = EPOCH_W'(SECS_PER_DAY);
         DSEL_QUAD: d = EPOCH_W'(DAYS_PER_QUAD);
         DSEL_HOUR: d = EPOCH_W'(SECS_PER_HOUR);
         DSEL_MIN:  d = EPOCH_W'(SECS_PER_MIN);
         default:   d = EPOCH_W'(SECS_PER_MIN);
      endcase
      return d;
   endfunction

   // Scaled reciprocal of the divisor selected by a control word
   function automatic logic [RECIP_W-1:0] recip(input dsel_type sel);
      logic [RECIP_W-1:0] r;
      case (sel)
         DSEL_DAY:  r = RECIP_DAY;
         DSEL_QUAD: r = RECIP_QUAD;
         DSEL_HOUR: r = RECIP_HOUR;
         DSEL_MIN:  r = RECIP_MIN;
         default:   r = RECIP_MIN;
      endcase
      return r;
   endfunction

   // First day of year of each month; one more from March on in a leap year
   function automatic logic [YDAY_W-1:0] month_start(input logic [MONTH_W-1:0] mon,
                                                      input logic leap);
      logic [YDAY_W-1:0] s;
      case (mon)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd59;
         4'd3:    s = 9'd90;
         4'd4:    s = 9'd120;
         4'd5:    s = 9'd151;
         4'd6:    s = 9'd181;
         4'd7:    s = 9'd212;
         4'd8:    s = 9'd243;
         4'd9:    s = 9'd273;
         4'd10:   s = 9'd304;
         4'd11:   s = 9'd334;
         default: s = 9'd334;
      endcase
      if (leap && (mon >= 4'd2)) begin
         s = s + 9'd1;
      end
      return s;
   endfunction

endpackage : esc_pkg

`default_nettype wire

### sv/epoch_seconds_to_calendar_unit.sv
// Epoch-seconds to UTC calendar converter, top level.
// Uses esc_pkg for widths, constants and the sequencer program.
//
// Converts a count of seconds since 1970-01-01 00:00:00 UTC (31 bits, so up
// to 2038-01-19 03:14:07) into year, month, day of month, day of year,
// weekday, hour, minute and second, with a leap year every fourth year.
// One item is in work at a time: req_tready rises again at the same edge
// at which the result of the last item comes to stand on rsp_, so a new
// item is accepted only once the last one is through. The program runs
// four divisions by constants (a day, a four-year block, an hour and a
// minute), each done in four steps as a reciprocal multiplication, a
// back-multiplication, a subtraction and one correction, plus four steps
// that store partial results, one month step and the output step. The
// result sits in an output register, so a new item is accepted while an
// earlier result still waits for rsp_tready; the program then holds at its
// output step until that register is free.
`default_nettype none

module epoch_seconds_to_calendar_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [30:0] epoch_seconds, [31] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata    // [10:0] cal_year, [14:11] month_index,
                                         // [19:15] day_of_month, [28:20] day_of_year,
                                         // [31:29] weekday, [36:32] hour_of_day,
                                         // [42:37] minute_of_hour,
                                         // [48:43] second_of_minute, [55:49] zero
);

   import esc_pkg::*;

   localparam int unsigned RSP_BITS = YEAR_W + MONTH_W + MDAY_W + YDAY_W + WDAY_W
                                      + HOUR_W + MIN_W + SEC_W;
   localparam int unsigned RSP_PAD  = 56 - RSP_BITS;

   // Sequencer
   logic [PC_W-1:0]      pc_ff, pc_in;
   uword_type            uw;
   logic                 cond_ok;
   logic                 req_fire;
   logic                 out_free;

   // Datapath
   logic [EPOCH_W-1:0]   acc_ff, acc_in;
   logic [DAYS_W-1:0]    quo_ff, quo_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [TOD_W-1:0]     tod_ff, tod_in;
   logic [YEAR_W-1:0]    year_ff, year_in;
   logic [YDAY_W-1:0]    yday_ff, yday_in;
   logic                 leap_ff, leap_in;
   logic [WDAY_W-1:0]    wday_ff, wday_in;
   logic [MONTH_W-1:0]   mon_ff, mon_in;
   logic [MDAY_W-1:0]    mday_ff, mday_in;
   logic [HOUR_W-1:0]    hour_ff, hour_in;
   logic [MIN_W-1:0]     min_ff, min_in;
   logic [SEC_W-1:0]     sec_ff, sec_in;

   // Division by a constant
   logic [EPOCH_W-1:0]   div_val;
   logic [RECIP_W-1:0]   recip_val;
   logic [DAYS_W-1:0]    quo_est;
   logic [EPOCH_W-1:0]   back_prod;

   // Helpers for the calendar steps
   logic [5:0]           wsum1;
   logic [3:0]           wsum2;
   logic [3:0]           wsum3;
   logic [QDAY_W-1:0]    qday;
   logic [1:0]           yoff;
   logic [QDAY_W-1:0]    qbase;
   logic [QDAY_W-1:0]    qdiff;
   logic [MONTH_W-1:0]   mon_sel;
   logic [YDAY_W-1:0]    mday_full;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [55:0]          rsp_data_ff, rsp_data_in;

   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (pc_ff == PC_WAIT);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Fetch the control word and resolve the jump
   always_comb begin
      uw = ucode(pc_ff);
      case (uw.cond)
         COND_ALWAYS:   cond_ok = 1'b1;
         COND_ACCEPT:   cond_ok = req_fire;
         COND_OUT_FREE: cond_ok = out_free;
         default:       cond_ok = 1'b1;
      endcase
      pc_in = cond_ok ? uw.target : pc_ff;
   end

   // Result register: load on the output step, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((uw.op == OP_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{RSP_PAD{1'b0}}, sec_ff, min_ff, hour_ff, wday_ff,
                         yday_ff, mday_ff, mon_ff, year_ff};
      end
   end

   // Datapath controlled by the current word
   always_comb begin
      acc_in  = acc_ff;
      quo_in  = quo_ff;
      prod_in = prod_ff;
      tod_in  = tod_ff;
      year_in = year_ff;
      yday_in = yday_ff;
      leap_in = leap_ff;
      wday_in = wday_ff;
      mon_in  = mon_ff;
      mday_in = mday_ff;
      hour_in = hour_ff;
      min_in  = min_ff;
      sec_in  = sec_ff;

      // Quotient estimate from the reciprocal product, true or one short
      div_val   = divisor(uw.dsel);
      recip_val = recip(uw.dsel);
      quo_est   = prod_ff[RECIP_SHIFT +: DAYS_W];
      back_prod = EPOCH_W'(quo_est) * div_val;

      // Weekday: fold octal digits, since eight is one modulo seven
      wsum1 = 6'(quo_ff[2:0]) + 6'(quo_ff[5:3]) + 6'(quo_ff[8:6])
              + 6'(quo_ff[11:9]) + 6'(quo_ff[14:12]) + 6'(BASE_WEEKDAY);
      wsum2 = 4'(wsum1[2:0]) + 4'(wsum1[5:3]);
      wsum3 = 4'(wsum2[2:0]) + 4'(wsum2[3]);

      // Year within the four-year block: 365, 365, 366, 365 days
      qday = acc_ff[QDAY_W-1:0];
      if (qday < QDAY_W'(DAYS_YEAR)) begin
         yoff  = 2'd0;
         qbase = '0;
      end else if (qday < QDAY_W'(2 * DAYS_YEAR)) begin
         yoff  = 2'd1;
         qbase = QDAY_W'(DAYS_YEAR);
      end else if (qday < QDAY_W'(3 * DAYS_YEAR + 1)) begin
         yoff  = 2'd2;
         qbase = QDAY_W'(2 * DAYS_YEAR);
      end else begin
         yoff  = 2'd3;
         qbase = QDAY_W'(3 * DAYS_YEAR + 1);
      end
      qdiff = qday - qbase;

      // Month: last month whose first day is not past the day of year
      mon_sel = '0;
      for (int m = 1; m < 12; m++) begin
         if (yday_ff >= month_start(MONTH_W'(m), leap_ff)) begin
            mon_sel = MONTH_W'(m);
         end
      end
      mday_full = yday_ff - month_start(mon_sel, leap_ff) + YDAY_W'(1);

      case (uw.op)
         OP_WAIT: begin
            if (req_fire) begin
               acc_in = req_tdata[EPOCH_W-1:0];
               quo_in = '0;
            end
         end
         // Multiply the dividend by the scaled reciprocal
         OP_MUL: begin
            prod_in = PROD_W'(acc_ff) * PROD_W'(recip_val);
         end
         // Take the estimate and multiply it back by the divisor
         OP_QUO: begin
            quo_in  = quo_est;
            prod_in = PROD_W'(back_prod);
         end
         // Remainder of the estimate
         OP_REM: begin
            acc_in = acc_ff - prod_ff[EPOCH_W-1:0];
         end
         // Add the one missing unit where the remainder is still too large
         OP_FIX: begin
            if (acc_ff >= div_val) begin
               acc_in = acc_ff - div_val;
               quo_in = quo_ff + DAYS_W'(1);
            end
         end
         OP_SAVE_DAYS: begin
            tod_in  = acc_ff[TOD_W-1:0];
            acc_in  = EPOCH_W'(quo_ff);
            wday_in = (wsum3 == 4'd7) ? '0 : wsum3[WDAY_W-1:0];
            quo_in  = '0;
         end
         OP_SAVE_QUAD: begin
            year_in = YEAR_W'(BASE_YEAR) + {quo_ff[YEAR_W-3:0], 2'b00}
                      + YEAR_W'(yoff);
            yday_in = qdiff[YDAY_W-1:0];
            leap_in = (yoff == 2'd2);
            quo_in  = '0;
         end
         OP_MONTH: begin
            mon_in  = mon_sel;
            mday_in = mday_full[MDAY_W-1:0];
            acc_in  = EPOCH_W'(tod_ff);
            quo_in  = '0;
         end
         OP_SAVE_HOUR: begin
            hour_in = quo_ff[HOUR_W-1:0];
            quo_in  = '0;
         end
         OP_SAVE_MIN: begin
            min_in = quo_ff[MIN_W-1:0];
            sec_in = acc_ff[SEC_W-1:0];
         end
         OP_OUT: begin
            quo_in = quo_ff;
         end
         default: begin
            quo_in = quo_ff;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      quo_ff      <= quo_in;
      prod_ff     <= prod_in;
      tod_ff      <= tod_in;
      year_ff     <= year_in;
      yday_ff     <= yday_in;
      leap_ff     <= leap_in;
      wday_ff     <= wday_in;
      mon_ff      <= mon_in;
      mday_ff     <= mday_in;
      hour_ff     <= hour_in;
      min_ff      <= min_in;
      sec_ff      <= sec_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule : epoch_seconds_to_calendar_unit

`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for epoch_seconds_to_calendar_unit: converts seconds since 1970 into
// a UTC calendar breakdown in its own predictor and compares every result item field by field.
// Depends on esc_pkg and epoch_seconds_to_calendar_unit.
`default_nettype none

module tb_top;
   import esc_pkg::*;

   // Month numbers that the calendar arithmetic singles out
   localparam int unsigned JANUARY  = 0;
   localparam int unsigned FEBRUARY = 1;
   localparam int unsigned MARCH    = 2;
   localparam int unsigned DECEMBER = 11;

   localparam int unsigned IDLE_PCT        = 21;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES    = 80;
   localparam int unsigned FIRST_YEAR      = 1970;
   localparam int unsigned LAST_FULL_YEAR  = 2037;

   // Result item as it sits on rsp_tdata, lowest field last
   typedef struct packed {
      logic [6:0]        zero_fill;
      logic [SEC_W-1:0]  second_of_minute;
      logic [MIN_W-1:0]  minute_of_hour;
      logic [HOUR_W-1:0] hour_of_day;
      logic [WDAY_W-1:0] weekday;
      logic [YDAY_W-1:0] day_of_year;
      logic [MDAY_W-1:0] day_of_month;
      logic [MONTH_W-1:0] month_index;
      logic [YEAR_W-1:0] cal_year;
   } calendar_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [30:0] epoch_seconds, [31] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // cal_year, month_index, day_of_month, day_of_year,
                                   // weekday, hour_of_day, minute_of_hour,
                                   // second_of_minute, zero fill

   calendar_type expected_cal [$];
   logic        idle_on        = 1'b1;
   logic        hold_off_asked = 1'b0;
   int unsigned conversions_sent = 0;
   int unsigned results_seen     = 0;
   int unsigned corner_count     = 0;
   int unsigned hold_offs_done   = 0;
   int unsigned mismatches       = 0;

   epoch_seconds_to_calendar_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Calendar helpers, leap year every fourth year
   function automatic int unsigned year_days(input int unsigned yr);
      return ((yr % 4) == 0) ? 366 : 365;
   endfunction

   function automatic int unsigned month_days(input int unsigned yr, input int unsigned mo);
      int unsigned n;
      case (mo)
         FEBRUARY:         n = ((yr % 4) == 0) ? 29 : 28;
         3, 5, 8, 10:      n = 30;
         default:          n = 31;
      endcase
      return n;
   endfunction

   // Predict the calendar breakdown of one epoch_seconds value
   function automatic calendar_type calendar_of(input logic [EPOCH_W-1:0] secs);
      calendar_type c;
      int unsigned days;
      int unsigned tod;
      int unsigned yr;
      int unsigned mo;
      c    = '0;
      days = secs / SECS_PER_DAY;
      tod  = secs % SECS_PER_DAY;
      c.weekday = WDAY_W'((days + BASE_WEEKDAY) % 7);
      yr = BASE_YEAR;
      while (days >= year_days(yr)) begin
         days = days - year_days(yr);
         yr++;
      end
      c.day_of_year = YDAY_W'(days);
      mo = JANUARY;
      while (mo < DECEMBER && days >= month_days(yr, mo)) begin
         days = days - month_days(yr, mo);
         mo++;
      end
      c.cal_year         = YEAR_W'(yr);
      c.month_index      = MONTH_W'(mo);
      c.day_of_month     = MDAY_W'(days + 1);
      c.hour_of_day      = HOUR_W'(tod / SECS_PER_HOUR);
      c.minute_of_hour   = MIN_W'((tod % SECS_PER_HOUR) / SECS_PER_MIN);
      c.second_of_minute = SEC_W'(tod % SECS_PER_MIN);
      return c;
   endfunction

   // First second of a given month
   function automatic longint month_start_secs(input int unsigned yr, input int unsigned mo);
      int unsigned y;
      int unsigned m;
      longint      days;
      days = 0;
      for (y = BASE_YEAR; y < yr; y++) days = days + year_days(y);
      for (m = JANUARY; m < mo; m++) days = days + month_days(yr, m);
      return days * SECS_PER_DAY;
   endfunction

   // Offer one item, hold it until accepted, then queue its expected result
   task automatic send_seconds(input logic [EPOCH_W-1:0] secs);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, secs};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_cal.push_back(calendar_of(secs));
      conversions_sent++;
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Check each result item against the oldest prediction
   always @(posedge clock) begin
      calendar_type want;
      calendar_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = calendar_type'(rsp_tdata);
         results_seen++;
         if (expected_cal.size() == 0) begin
            $error("result item with no conversion pending");
            mismatches++;
         end else begin
            want = expected_cal.pop_front();
            compare_field("cal_year", want.cal_year, got.cal_year);
            compare_field("month_index", want.month_index, got.month_index);
            compare_field("day_of_month", want.day_of_month, got.day_of_month);
            compare_field("day_of_year", want.day_of_year, got.day_of_year);
            compare_field("weekday", want.weekday, got.weekday);
            compare_field("hour_of_day", want.hour_of_day, got.hour_of_day);
            compare_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
            compare_field("second_of_minute", want.second_of_minute, got.second_of_minute);
            compare_field("zero_fill", want.zero_fill, got.zero_fill);
         end
      end
   end

   // Result side: random back-pressure, or a long hold-off on request
   initial begin : rsp_side
      int unsigned held;
      forever begin
         @(negedge clock);
         if (hold_off_asked) begin
            hold_off_asked = 1'b0;
            rsp_tready <= 1'b0;
            for (held = 1; held < HOLD_OFF_CYCLES; held++) @(negedge clock);
            hold_offs_done++;
         end else if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Field extremes, minute/hour/day edges, leap days and year ends
   task automatic test_corner_cases();
      logic [EPOCH_W-1:0] corners [$];
      int unsigned        i;
      corners = '{31'd0, 31'd59, 31'd60, 31'd3599, 31'd3600, 31'd86399, 31'd86400,
                  31'd31535999, 31'd31536000,        // end of 1970, start of 1971
                  31'd36547200, 31'd36633600,        // 28 Feb and 1 Mar of a common year
                  31'd63072000, 31'd68169600,        // start of 1972, 29 Feb 1972
                  31'd68255999, 31'd68256000,        // last second of the leap day, 1 Mar
                  31'd94608000, 31'd94694399,        // last day of a leap year
                  31'd94694400,                      // first day after a leap year
                  31'd951782400, 31'd2114294400,     // 29 Feb 2000, 31 Dec 2036
                  31'd2145916799, 31'd2145916800,    // turn of 2037 into 2038
                  31'h2AAAAAAA, 31'h55555555,
                  31'h7FFFFFFF};                     // latest representable instant
      for (i = 0; i < corners.size(); i++) send_seconds(corners[i]);
      corner_count = corners.size();
   endtask

   // Random instants near the start of a year or month, with leap Februaries weighted
   task automatic test_calendar_edges(input int unsigned count);
      int unsigned i;
      int unsigned yr;
      int unsigned mo;
      int          off;
      longint      base;
      for (i = 0; i < count; i++) begin
         yr = $urandom_range(FIRST_YEAR, LAST_FULL_YEAR);
         mo = $urandom_range(JANUARY, DECEMBER);
         case ($urandom_range(3))
            0: mo = JANUARY;
            1: begin
               yr = 1972 + 4 * $urandom_range(0, 16);
               mo = MARCH;
            end
            default: ;
         endcase
         if ($urandom_range(2) == 0) begin
            off = int'($urandom_range(0, 4)) - 2;
         end else begin
            off = int'($urandom_range(0, 2 * SECS_PER_DAY)) - int'(SECS_PER_DAY);
         end
         base = month_start_secs(yr, mo);
         send_seconds(EPOCH_W'(base + off));
      end
   endtask

   // Uniform random instants over the whole 31-bit span
   task automatic test_full_range(input int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++) send_seconds(EPOCH_W'($urandom));
   endtask

   // Random instants with neither side idling
   task automatic test_back_to_back(input int unsigned count);
      idle_on = 1'b0;
      test_full_range(count);
      idle_on = 1'b1;
   endtask

   // Stall the result side for a long stretch while items keep coming
   task automatic test_output_hold_off(input int unsigned count);
      hold_off_asked = 1'b1;
      test_full_range(count);
   endtask

   initial begin : run
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_corner_cases();
      test_calendar_edges(350);
      test_full_range(480);
      test_back_to_back(220);
      test_output_hold_off(12);
      test_calendar_edges(40);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_cal.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Converted %0d instants (%0d corner cases), %0d results checked,",
               conversions_sent, corner_count, results_seen);
      $display("covering year/month/leap-day edges, the full range and %0d output hold-off(s)",
               hold_offs_done);
      if (mismatches == 0) begin
         $display("epoch_seconds_to_calendar_unit: match");
      end else begin
         $display("epoch_seconds_to_calendar_unit: mismatch");
      end
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #4000000;
      $display("Timed out with %0d results still pending", expected_cal.size());
      $display("epoch_seconds_to_calendar_unit: mismatch");
      $finish;
   end

endmodule : tb_top

`default_nettype wire

### filelist.f
sv/esc_pkg.sv
sv/epoch_seconds_to_calendar_unit.sv
tb/tb_top.sv
